// ===== design/vram_dma_chunk_splitter_assert.svh =====
// Assertion macros for the VRAM DMA chunk splitter.
// Used by the top level only; no other dependencies.
`ifndef VRAM_DMA_CHUNK_SPLITTER_ASSERT_SVH
`define VRAM_DMA_CHUNK_SPLITTER_ASSERT_SVH

// A condition that holds at every clock edge outside reset.
`define VDCS_ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("vdcs: invariant violated");

// A condition that follows from another in the same cycle.
`define VDCS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vdcs: implication violated");

`endif

// ===== design/vdcs_pkg.sv =====
// Package for the VRAM DMA chunk splitter: widths, codes and item types.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package vdcs_pkg;

  localparam int unsigned ADDR_W    = 16;
  localparam int unsigned COUNT_W   = 12;
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned MODE_W    = 2;
  localparam int unsigned ACT_W     = 2;
  localparam int unsigned ROW_W     = 6;
  localparam int unsigned BIT_W     = 8;
  localparam int unsigned CFG_IDX_W = 1;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;
  localparam int unsigned QCNT_W      = 2;

  localparam logic [COUNT_W-1:0] MAX_COUNT  = 12'd2048;
  localparam logic [ADDR_W-1:0]  DEST_BASE  = 16'h8000;
  localparam logic [ADDR_W-1:0]  MAP_BASE   = 16'h9800;

  localparam logic [CMD_W-1:0] CMD_LOAD_SRC = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_DST = 2'd1;
  localparam logic [CMD_W-1:0] CMD_XFER     = 2'd2;

  localparam logic [MODE_W-1:0] MODE_NO_COPY = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PACKET  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_DMA_MODE    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PACKET_BASE = 1'b1;

  typedef enum logic [ACT_W-1:0] {
    ACT_NONE   = 2'd0,
    ACT_TILE   = 2'd1,
    ACT_MAP    = 2'd2,
    ACT_FINISH = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    OP_LOAD_SRC,
    OP_LOAD_DST,
    OP_XFER
  } op_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SRC,
    B_DST
  } back_state_t;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [ADDR_W-1:0]  new_source;
    logic [ADDR_W-1:0]  new_dest;
    logic [COUNT_W-1:0] byte_count;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  chunk_source;
    logic [ADDR_W-1:0]  chunk_dest;
    logic [COUNT_W-1:0] chunk_count;
    logic [ACT_W-1:0]   action;
    logic [ROW_W-1:0]   map_row;
    logic [BIT_W-1:0]   dirty_first_bit;
    logic [BIT_W-1:0]   dirty_end_bit;
    logic               last_chunk;
  } out_item_t;

  typedef struct packed {
    op_t                op;
    logic [ADDR_W-1:0]  addr;
    logic [COUNT_W-1:0] count;
  } op_item_t;

  typedef struct packed {
    logic     valid;
    op_item_t item;
  } push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic [MODE_W-1:0] dma_mode;
    logic [ADDR_W-1:0] packet_base_addr;
  } cfg_t;

  typedef struct packed {
    logic               busy;
    logic [COUNT_W-1:0] left;
  } back_stat_t;

endpackage

// ===== design/vdcs_front.sv =====
// Front end of the chunk splitter: decodes commands into queue operations.
// Depends on vdcs_pkg.
`timescale 1ns / 1ps

module vdcs_front (
  input  logic              in_valid,
  output logic              in_stall,
  input  vdcs_pkg::in_item_t in_item,
  input  vdcs_pkg::q_stat_t q_stat,
  output vdcs_pkg::push_t   push
);

  logic                          take;
  logic [vdcs_pkg::COUNT_W-1:0]  sat_count;

  assign in_stall  = q_stat.full;
  assign take      = in_valid && !q_stat.full;
  assign sat_count = (in_item.byte_count > vdcs_pkg::MAX_COUNT) ?
                     vdcs_pkg::MAX_COUNT : in_item.byte_count;

  // Unknown commands and empty transfers are consumed without a queue entry.
  always_comb begin
    push.valid      = 1'b0;
    push.item.op    = vdcs_pkg::OP_XFER;
    push.item.addr  = in_item.new_source;
    push.item.count = sat_count;
    case (in_item.command)
      vdcs_pkg::CMD_LOAD_SRC: begin
        push.valid   = take;
        push.item.op = vdcs_pkg::OP_LOAD_SRC;
      end
      vdcs_pkg::CMD_LOAD_DST: begin
        push.valid     = take;
        push.item.op   = vdcs_pkg::OP_LOAD_DST;
        push.item.addr = {3'b100, in_item.new_dest[12:0]};
      end
      vdcs_pkg::CMD_XFER: begin
        push.valid = take && (in_item.byte_count != '0);
      end
      default: begin
        push.valid = 1'b0;
      end
    endcase
  end

endmodule

// ===== design/vdcs_queue.sv =====
// Short register queue between the front and back ends of the splitter.
// Depends on vdcs_pkg.
`timescale 1ns / 1ps

module vdcs_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  vdcs_pkg::push_t    push,
  input  logic               pop,
  output vdcs_pkg::op_item_t q_item,
  output vdcs_pkg::q_stat_t  q_stat
);

  vdcs_pkg::op_item_t              mem_r [vdcs_pkg::QUEUE_DEPTH];
  logic [vdcs_pkg::QPTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [vdcs_pkg::QPTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [vdcs_pkg::QCNT_W-1:0]     cnt_r, cnt_nxt;

  localparam logic [vdcs_pkg::QPTR_W-1:0] LAST_PTR =
    vdcs_pkg::QPTR_W'(vdcs_pkg::QUEUE_DEPTH - 1);
  localparam logic [vdcs_pkg::QCNT_W-1:0] FULL_CNT =
    vdcs_pkg::QCNT_W'(vdcs_pkg::QUEUE_DEPTH);

  assign q_item       = mem_r[rd_ptr_r];
  assign q_stat.full  = (cnt_r == FULL_CNT);
  assign q_stat.empty = (cnt_r == '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push.valid) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push.valid, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem_r[wr_ptr_r] <= push.item;
    end
  end

endmodule

// ===== design/vdcs_back.sv =====
// Back end of the chunk splitter: owns the pointers and emits one chunk
// at a time through an output register. Depends on vdcs_pkg.
`timescale 1ns / 1ps

module vdcs_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  vdcs_pkg::cfg_t       cfg,
  input  vdcs_pkg::op_item_t   q_item,
  input  vdcs_pkg::q_stat_t    q_stat,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output vdcs_pkg::out_item_t  out_item,
  output vdcs_pkg::back_stat_t stat
);

  localparam int unsigned AW = vdcs_pkg::ADDR_W;
  localparam int unsigned CW = vdcs_pkg::COUNT_W;

  vdcs_pkg::back_state_t state_r, state_nxt;
  logic [AW-1:0]         src_ptr_r, src_ptr_nxt;
  logic [AW-1:0]         dst_ptr_r, dst_ptr_nxt;
  logic [CW-1:0]         left_r, left_nxt;
  logic [CW-1:0]         cnt1_r, cnt1_nxt;
  logic                  out_valid_r, out_valid_nxt;
  vdcs_pkg::out_item_t   out_item_r, out_item_nxt;

  logic                  out_free;
  logic                  emit;

  // Source side limit.
  logic [AW:0]           send, slast, sblk, seblk;
  logic [CW-1:0]         src_cnt;

  // Destination side limit and chunk fields.
  logic [AW-1:0]         dend, dlast, dblk, deblk, dend_sel, map_off;
  logic                  dclip;
  logic [CW-1:0]         cnt, new_left;
  logic [14:0]           end_off;
  logic [15:0]           end_sum;
  logic [12:0]           etile_p1;
  vdcs_pkg::action_t     act;
  vdcs_pkg::out_item_t   chunk;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    send  = {1'b0, src_ptr_r} + {{(AW + 1 - CW){1'b0}}, left_r};
    slast = send - 1'b1;
    if (src_ptr_r[AW-1]) begin
      sblk  = {1'b0, src_ptr_r & 16'hF000};
      seblk = slast & 17'h1F000;
    end else begin
      sblk  = {1'b0, src_ptr_r & 16'hC000};
      seblk = slast & 17'h1C000;
    end
    src_cnt = (seblk != sblk) ? CW'(seblk - {1'b0, src_ptr_r}) : left_r;
  end

  always_comb begin
    dend     = dst_ptr_r + {{(AW - CW){1'b0}}, cnt1_r};
    dlast    = dend - 1'b1;
    dblk     = dst_ptr_r & 16'hF800;
    deblk    = dlast & 16'hF800;
    dclip    = (deblk != dblk);
    cnt      = dclip ? CW'(deblk - dst_ptr_r) : cnt1_r;
    dend_sel = dclip ? deblk : dend;
    new_left = left_r - cnt;
    map_off  = dst_ptr_r - vdcs_pkg::MAP_BASE;
    end_off  = dend_sel[14:0];
    end_sum  = {1'b0, end_off} + 16'd15;
    etile_p1 = {1'b0, end_sum[15:4]} + 13'd1;

    if (cfg.dma_mode == vdcs_pkg::MODE_NO_COPY) begin
      act = vdcs_pkg::ACT_NONE;
    end else if (cfg.dma_mode == vdcs_pkg::MODE_PACKET && dst_ptr_r == vdcs_pkg::DEST_BASE &&
                 src_ptr_r == cfg.packet_base_addr) begin
      act = vdcs_pkg::ACT_FINISH;
    end else if (dst_ptr_r >= vdcs_pkg::MAP_BASE) begin
      act = vdcs_pkg::ACT_MAP;
    end else begin
      act = vdcs_pkg::ACT_TILE;
    end

    chunk.chunk_source    = src_ptr_r;
    chunk.chunk_dest      = dst_ptr_r;
    chunk.chunk_count     = cnt;
    chunk.action          = act;
    chunk.map_row         = (act == vdcs_pkg::ACT_MAP) ? map_off[10:5] : '0;
    chunk.dirty_first_bit = (act == vdcs_pkg::ACT_TILE) ? dst_ptr_r[12:5] : '0;
    chunk.dirty_end_bit   = (act == vdcs_pkg::ACT_TILE) ? etile_p1[8:1] : '0;
    chunk.last_chunk      = (new_left == '0);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      vdcs_pkg::B_IDLE: begin
        if (!q_stat.empty && q_item.op == vdcs_pkg::OP_XFER) begin
          state_nxt = vdcs_pkg::B_SRC;
        end
      end
      vdcs_pkg::B_SRC: begin
        state_nxt = vdcs_pkg::B_DST;
      end
      vdcs_pkg::B_DST: begin
        if (out_free) begin
          state_nxt = (new_left == '0) ? vdcs_pkg::B_IDLE : vdcs_pkg::B_SRC;
        end
      end
      default: begin
        state_nxt = vdcs_pkg::B_IDLE;
      end
    endcase
  end

  always_comb begin
    pop  = 1'b0;
    emit = 1'b0;
    case (state_r)
      vdcs_pkg::B_IDLE: pop  = !q_stat.empty;
      vdcs_pkg::B_DST:  emit = out_free;
      default: begin
        pop  = 1'b0;
        emit = 1'b0;
      end
    endcase
  end

  always_comb begin
    src_ptr_nxt   = src_ptr_r;
    dst_ptr_nxt   = dst_ptr_r;
    left_nxt      = left_r;
    cnt1_nxt      = cnt1_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_item_nxt  = out_item_r;
    if (pop) begin
      case (q_item.op)
        vdcs_pkg::OP_LOAD_SRC: src_ptr_nxt = q_item.addr;
        vdcs_pkg::OP_LOAD_DST: dst_ptr_nxt = q_item.addr;
        vdcs_pkg::OP_XFER:     left_nxt    = q_item.count;
        default:               left_nxt    = left_r;
      endcase
    end
    if (state_r == vdcs_pkg::B_SRC) begin
      cnt1_nxt = src_cnt;
    end
    if (emit) begin
      src_ptr_nxt   = src_ptr_r + {{(AW - CW){1'b0}}, cnt};
      dst_ptr_nxt   = {3'b100, dend_sel[12:0]};
      left_nxt      = new_left;
      out_valid_nxt = 1'b1;
      out_item_nxt  = chunk;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= vdcs_pkg::B_IDLE;
      src_ptr_r   <= '0;
      dst_ptr_r   <= vdcs_pkg::DEST_BASE;
      left_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      src_ptr_r   <= src_ptr_nxt;
      dst_ptr_r   <= dst_ptr_nxt;
      left_r      <= left_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt1_r     <= cnt1_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign stat.busy = (state_r != vdcs_pkg::B_IDLE);
  assign stat.left = left_r;

endmodule

// ===== design/vram_dma_chunk_splitter.sv =====
// Top level of the VRAM DMA chunk splitter: configuration registers,
// front end, command queue and back end. Depends on vdcs_pkg, vdcs_front,
// vdcs_queue, vdcs_back and vram_dma_chunk_splitter_assert.svh.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall   | in_item (command, pointers, count)
//   out_    | output    | out_valid/out_stall | out_item (one chunk)
//   cfg_    | input     | cfg_we              | cfg_index, cfg_wdata
//
// A load leaves the queue and updates its pointer as it is popped. A transfer leaves
// the queue and is then split into chunks, each by a source split and then a
// destination split, so one transfer gives at most three chunks.
// The two-entry queue lets the front take items while the back end works.
// Reset is synchronous: pointers go to source 0 and destination 0x8000.
// A stalled chunk holds in the output register and the back end waits.
`timescale 1ns / 1ps

`include "vram_dma_chunk_splitter_assert.svh"

module vram_dma_chunk_splitter (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  vdcs_pkg::in_item_t               in_item,
  output logic                             out_valid,
  input  logic                             out_stall,
  output vdcs_pkg::out_item_t              out_item,
  input  logic                             cfg_we,
  input  logic [vdcs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [vdcs_pkg::ADDR_W-1:0]      cfg_wdata
);

  vdcs_pkg::cfg_t       cfg_r, cfg_nxt;
  vdcs_pkg::push_t      push;
  vdcs_pkg::q_stat_t    q_stat;
  vdcs_pkg::op_item_t   q_item;
  vdcs_pkg::back_stat_t back_stat;
  logic                 pop;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        vdcs_pkg::CFG_DMA_MODE:    cfg_nxt.dma_mode = cfg_wdata[vdcs_pkg::MODE_W-1:0];
        vdcs_pkg::CFG_PACKET_BASE: cfg_nxt.packet_base_addr = cfg_wdata;
        default:                   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  vdcs_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_stat   (q_stat),
    .push     (push)
  );

  vdcs_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .pop    (pop),
    .q_item (q_item),
    .q_stat (q_stat)
  );

  vdcs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_item    (q_item),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .stat      (back_stat)
  );

  `VDCS_ASSERT_IMPLY(a_dest_window, clk, rst_n, out_valid, out_item.chunk_dest[15:13] == 3'b100)
  `VDCS_ASSERT_IMPLY(a_dirty_order, clk, rst_n, out_valid && out_item.action == vdcs_pkg::ACT_TILE, out_item.dirty_first_bit < out_item.dirty_end_bit)
  `VDCS_ASSERT_IMPLY(a_idle_drained, clk, rst_n, !back_stat.busy, back_stat.left == '0)
  `VDCS_ASSERT_ALWAYS(a_left_bound, clk, rst_n, back_stat.left <= vdcs_pkg::MAX_COUNT)

endmodule
